/* hw/rtl/cfc_pkg.sv */
// cfc_pkg: beat types, queue entry type, verdict and register codes
// shared by the command frame checker front, queue, back and top level
// no dependencies
package cfc_pkg;

  // frame constants
  localparam logic [7:0] HDR_FIRST       = 8'h4A;
  localparam logic [7:0] HDR_SECOND      = 8'h48;
  localparam logic [7:0] ACK_BIT         = 8'h80;
  localparam logic [7:0] MAX_FRAME_BYTES = 8'd20;
  localparam logic [7:0] COUNT_SAT       = 8'hFF;
  localparam logic [7:0] MIN_FRAME_BYTES = 8'd6;
  localparam logic [8:0] FRAME_OVERHEAD  = 9'd6;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = 2;
  localparam int unsigned QUEUE_CNT_W = 3;

  // verdict codes
  localparam logic [3:0] VERDICT_REPLY      = 4'd0;
  localparam logic [3:0] VERDICT_START      = 4'd1;
  localparam logic [3:0] VERDICT_STOP       = 4'd2;
  localparam logic [3:0] VERDICT_RESTART    = 4'd3;
  localparam logic [3:0] VERDICT_TRANSFER   = 4'd4;
  localparam logic [3:0] VERDICT_UNKNOWN    = 4'd5;
  localparam logic [3:0] VERDICT_BAD_LENGTH = 4'd6;
  localparam logic [3:0] VERDICT_CHECKSUM   = 4'd7;
  localparam logic [3:0] VERDICT_BAD_HEADER = 4'd8;

  // frame class found by the front
  localparam logic [1:0] CLS_GOOD       = 2'd0;
  localparam logic [1:0] CLS_BAD_HEADER = 2'd1;
  localparam logic [1:0] CLS_BAD_LENGTH = 2'd2;
  localparam logic [1:0] CLS_CHECKSUM   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_START_SAMPLE   = 2'd0;
  localparam logic [1:0] REG_STOP_SAMPLE    = 2'd1;
  localparam logic [1:0] REG_RESTART_SAMPLE = 2'd2;
  localparam logic [1:0] REG_START_TRANSFER = 2'd3;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       end_of_packet;
  } in_beat_t;

  typedef struct packed {
    logic [3:0] verdict;
    logic [7:0] rx_opcode;
    logic [7:0] ack_opcode;
    logic       ack_needed;
    logic       sampling_on;
  } out_beat_t;

  // one queue entry: a local command or a classified packet end
  typedef struct packed {
    logic       is_cmd;
    logic [1:0] cls;
    logic [7:0] opcode;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* hw/rtl/cfc_front.sv */
// cfc_front: takes input beats, tracks the packet in progress and
// classifies each packet end; depends on cfc_pkg
module cfc_front
  import cfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  input  q_status_t q_status,
  output logic      q_push,
  output q_entry_t  q_wdata
);

  logic [7:0] byte_count_r, byte_count_nxt;
  logic [7:0] running_sum_r, running_sum_nxt;
  logic       header_good_r, header_good_nxt;
  logic [7:0] held_opcode_r, held_opcode_nxt;
  logic [7:0] held_length_r, held_length_nxt;

  logic       accept;
  logic       hdr_ok;
  logic [7:0] count;
  logic [7:0] opc;
  logic       len_bad;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    hdr_ok = header_good_r;
    if (byte_count_r == 8'd0 && in_data.data_byte != HDR_FIRST) hdr_ok = 1'b0;
    if (byte_count_r == 8'd1 && in_data.data_byte != HDR_SECOND) hdr_ok = 1'b0;
    held_opcode_nxt = (byte_count_r == 8'd3) ? in_data.data_byte : held_opcode_r;
    held_length_nxt = (byte_count_r == 8'd4) ? in_data.data_byte : held_length_r;
    count = (byte_count_r == COUNT_SAT) ? COUNT_SAT : byte_count_r + 8'd1;
    opc   = (count >= 8'd4) ? held_opcode_nxt : 8'd0;
    len_bad = (count < MIN_FRAME_BYTES) || (count == COUNT_SAT) ||
              (count > MAX_FRAME_BYTES) ||
              ({1'b0, count} != ({1'b0, held_length_nxt} + FRAME_OVERHEAD));
  end

  // classify the packet end, or pass a local command on with the ack bit set
  always_comb begin
    q_wdata = '0;
    if (in_data.kind) begin
      q_wdata.is_cmd = 1'b1;
      q_wdata.cls    = CLS_GOOD;
      q_wdata.opcode = in_data.data_byte | ACK_BIT;
    end else begin
      q_wdata.is_cmd = 1'b0;
      q_wdata.opcode = opc;
      priority if (!hdr_ok || count < 8'd2) begin
        q_wdata.cls    = CLS_BAD_HEADER;
        q_wdata.opcode = 8'd0;
      end else if (len_bad) begin
        q_wdata.cls = CLS_BAD_LENGTH;
      end else if (running_sum_r != in_data.data_byte) begin
        q_wdata.cls = CLS_CHECKSUM;
      end else begin
        q_wdata.cls = CLS_GOOD;
      end
    end
  end

  assign q_push = accept && (in_data.kind || in_data.end_of_packet);

  always_comb begin
    byte_count_nxt  = byte_count_r;
    running_sum_nxt = running_sum_r;
    header_good_nxt = header_good_r;
    if (accept && !in_data.kind) begin
      if (in_data.end_of_packet) begin
        byte_count_nxt  = 8'd0;
        running_sum_nxt = 8'd0;
        header_good_nxt = 1'b1;
      end else begin
        byte_count_nxt  = count;
        running_sum_nxt = running_sum_r + in_data.data_byte;
        header_good_nxt = hdr_ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r  <= 8'd0;
      running_sum_r <= 8'd0;
      header_good_r <= 1'b1;
      held_opcode_r <= 8'd0;
      held_length_r <= 8'd0;
    end else begin
      byte_count_r  <= byte_count_nxt;
      running_sum_r <= running_sum_nxt;
      header_good_r <= header_good_nxt;
      if (accept && !in_data.kind) begin
        held_opcode_r <= in_data.end_of_packet ? 8'd0 : held_opcode_nxt;
        held_length_r <= in_data.end_of_packet ? 8'd0 : held_length_nxt;
      end
    end
  end

endmodule

/* hw/rtl/cfc_queue.sv */
// cfc_queue: short first-in first-out queue of classified entries
// between front and back; depends on cfc_pkg
module cfc_queue
  import cfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  q_entry_t  wdata,
  input  logic      pop,
  output q_entry_t  rdata,
  output q_status_t status
);

  q_entry_t                 slot_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QUEUE_CNT_W-1:0]   count_r, count_nxt;

  assign status.full  = (count_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign rdata        = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!status.full || pop))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty)
    else $error("queue pop while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QUEUE_CNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");
`endif

endmodule

/* hw/rtl/cfc_back.sv */
// cfc_back: carries out queued entries, holds the reply wait, sampling
// flag and command opcode registers, drives the result register; uses cfc_pkg
module cfc_back
  import cfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  q_entry_t  q_rdata,
  input  q_status_t q_status,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  logic [7:0] start_op_r, stop_op_r, restart_op_r, transfer_op_r;
  logic       awaiting_r, awaiting_nxt;
  logic [7:0] awaited_op_r, awaited_op_nxt;
  logic       sampling_r, sampling_nxt;
  logic       out_valid_r;
  out_beat_t  out_data_r;
  out_beat_t  res;
  logic       out_free;
  logic       load;

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = !q_status.empty && (q_rdata.is_cmd || out_free);
  assign load     = q_pop && !q_rdata.is_cmd;

  always_comb begin
    awaiting_nxt   = awaiting_r;
    awaited_op_nxt = awaited_op_r;
    sampling_nxt   = sampling_r;
    res            = '0;
    res.rx_opcode  = q_rdata.opcode;
    res.ack_needed = 1'b1;
    if (q_pop && q_rdata.is_cmd) begin
      awaiting_nxt   = 1'b1;
      awaited_op_nxt = q_rdata.opcode;
    end
    unique case (q_rdata.cls)
      CLS_BAD_HEADER: begin
        res.verdict    = VERDICT_BAD_HEADER;
        res.ack_needed = 1'b0;
      end
      CLS_BAD_LENGTH: res.verdict = VERDICT_BAD_LENGTH;
      CLS_CHECKSUM:   res.verdict = VERDICT_CHECKSUM;
      default: begin
        if (awaiting_r && awaited_op_r == q_rdata.opcode) begin
          res.verdict    = VERDICT_REPLY;
          res.ack_needed = 1'b0;
          if (load) begin
            awaiting_nxt   = 1'b0;
            awaited_op_nxt = 8'd0;
          end
        end else begin
          priority if (q_rdata.opcode == start_op_r) begin
            res.verdict = VERDICT_START;
            if (load) sampling_nxt = 1'b1;
          end else if (q_rdata.opcode == stop_op_r) begin
            res.verdict = VERDICT_STOP;
            if (load) sampling_nxt = 1'b0;
          end else if (q_rdata.opcode == restart_op_r) begin
            res.verdict = VERDICT_RESTART;
          end else if (q_rdata.opcode == transfer_op_r) begin
            res.verdict = VERDICT_TRANSFER;
          end else begin
            res.verdict = VERDICT_UNKNOWN;
          end
        end
      end
    endcase
    res.ack_opcode  = res.ack_needed ? (q_rdata.opcode | ACK_BIT) : 8'd0;
    res.sampling_on = sampling_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_op_r    <= 8'd1;
      stop_op_r     <= 8'd2;
      restart_op_r  <= 8'd3;
      transfer_op_r <= 8'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_SAMPLE:   start_op_r    <= cfg_data;
        REG_STOP_SAMPLE:    stop_op_r     <= cfg_data;
        REG_RESTART_SAMPLE: restart_op_r  <= cfg_data;
        REG_START_TRANSFER: transfer_op_r <= cfg_data;
        default:            start_op_r    <= start_op_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r   <= 1'b0;
      awaited_op_r <= 8'd0;
      sampling_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      awaiting_r   <= awaiting_nxt;
      awaited_op_r <= awaited_op_nxt;
      sampling_r   <= sampling_nxt;
      if (load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_reply_clears_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (load && res.verdict == VERDICT_REPLY) |=> !awaiting_r)
    else $error("reply matched but wait still armed");

  a_ack_opcode_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.ack_needed) |->
      (out_data_r.ack_opcode == (out_data_r.rx_opcode | ACK_BIT)))
    else $error("ack opcode does not match frame opcode");

  a_sampling_tracks_result: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (out_data_r.sampling_on == sampling_r))
    else $error("result sampling flag differs from state");
`endif

endmodule

/* hw/rtl/command_frame_checker.sv */
// command_frame_checker: top level of the command frame checker
// instantiates cfc_front, cfc_queue and cfc_back; uses cfc_pkg
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   in_beat_t  (kind, data_byte, end_of_packet)
//   out_     output     out_valid / out_stall out_beat_t (verdict .. sampling_on)
//   cfg_     input      cfg_we                cfg_index 2 bits, cfg_data 8 bits
//
// one input beat per cycle while in_stall is low; the front updates the running sum and
// header checks in the cycle a byte is taken, so the rate is one byte per clock unless
// stalled; a packet end or a local command goes into a four-entry queue, and the back
// takes one entry per cycle while out_ is free; a verdict passes the queue slot and
// the result register to out_; in_stall rises only when the queue is full; out_stall
// holds the result register and backs up the queue, local commands still drain past it
// rst_n is synchronous: packet state cleared, header flag set, wait and
// sampling flag cleared, command opcodes back to 1, 2, 3, 4
module command_frame_checker
  import cfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_beat_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_beat_t  out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  // queue hookup
  logic      q_push;
  logic      q_pop;
  q_entry_t  q_wdata;
  q_entry_t  q_rdata;
  q_status_t q_status;

  // front: byte tracking and packet classification
  cfc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_status (q_status),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  // decoupling queue
  cfc_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .status (q_status)
  );

  // back: reply wait, dispatch, sampling flag, result register
  cfc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_rdata   (q_rdata),
    .q_status  (q_status),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* verif/cfc_checker.sv */
`timescale 1ns / 100ps
// cfc_checker: watches the in_, out_ and cfg_ ports of command_frame_checker,
// predicts each verdict from its own copy of the frame state and compares
// depends on cfc_pkg for the beat types, verdict codes and register indexes
module cfc_checker
  import cfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_beat_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_beat_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int unsigned fail_count,
  output int unsigned verdicts_pending,
  output int unsigned verdicts_checked
);

  localparam logic [7:0] SYNC_0      = 8'h4A;
  localparam logic [7:0] SYNC_1      = 8'h48;
  localparam logic [7:0] REPLY_BIT   = 8'h80;
  localparam logic [7:0] COUNT_TOP   = 8'hFF;
  localparam int         FRAME_LIMIT = 20;
  localparam int         FRAME_EXTRA = 6;

  logic [7:0] start_op, stop_op, restart_op, transfer_op;
  logic [7:0] seen_bytes, byte_sum, opcode_seen, length_seen, reply_opcode;
  logic       header_ok, reply_armed, sampling;
  out_beat_t  expected_verdicts[$];

  initial begin
    fail_count       = 0;
    verdicts_pending = 0;
    verdicts_checked = 0;
  end

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("verdict %0d %s got 0x%02h want 0x%02h",
                                verdicts_checked, name, got, want));
  endtask

  task automatic forget_packet();
    seen_bytes  = '0;
    byte_sum    = '0;
    header_ok   = 1'b1;
    opcode_seen = '0;
    length_seen = '0;
  endtask

  task automatic take_beat(input in_beat_t b);
    out_beat_t  v;
    logic [7:0] op;
    logic       ack;
    v = '0;
    if (b.kind) begin
      reply_armed  = 1'b1;
      reply_opcode = b.data_byte | REPLY_BIT;
      return;
    end
    if (seen_bytes == 8'd0 && b.data_byte != SYNC_0) header_ok = 1'b0;
    if (seen_bytes == 8'd1 && b.data_byte != SYNC_1) header_ok = 1'b0;
    if (seen_bytes == 8'd3) opcode_seen = b.data_byte;
    if (seen_bytes == 8'd4) length_seen = b.data_byte;
    if (seen_bytes != COUNT_TOP) seen_bytes++;
    if (!b.end_of_packet) begin
      byte_sum = byte_sum + b.data_byte;
      return;
    end
    op  = (seen_bytes >= 8'd4) ? opcode_seen : 8'd0;
    ack = 1'b1;
    if (!header_ok || seen_bytes < 8'd2) begin
      v.verdict = VERDICT_BAD_HEADER;
      op        = '0;
      ack       = 1'b0;
    end else if (int'(seen_bytes) < FRAME_EXTRA || seen_bytes == COUNT_TOP
                 || int'(seen_bytes) > FRAME_LIMIT
                 || int'(seen_bytes) != int'(length_seen) + FRAME_EXTRA) begin
      v.verdict = VERDICT_BAD_LENGTH;
    end else if (byte_sum != b.data_byte) begin
      v.verdict = VERDICT_CHECKSUM;
    end else if (reply_armed && reply_opcode == op) begin
      reply_armed  = 1'b0;
      reply_opcode = '0;
      v.verdict    = VERDICT_REPLY;
      ack          = 1'b0;
    end else if (op == start_op) begin
      sampling  = 1'b1;
      v.verdict = VERDICT_START;
    end else if (op == stop_op) begin
      sampling  = 1'b0;
      v.verdict = VERDICT_STOP;
    end else if (op == restart_op) begin
      v.verdict = VERDICT_RESTART;
    end else if (op == transfer_op) begin
      v.verdict = VERDICT_TRANSFER;
    end else begin
      v.verdict = VERDICT_UNKNOWN;
    end
    forget_packet();
    v.rx_opcode   = op;
    v.ack_opcode  = ack ? (op | REPLY_BIT) : 8'd0;
    v.ack_needed  = ack;
    v.sampling_on = sampling;
    expected_verdicts.push_back(v);
  endtask

  always @(posedge clk) begin : watch
    out_beat_t want;
    if (!rst_n) begin
      start_op     = 8'd1;
      stop_op      = 8'd2;
      restart_op   = 8'd3;
      transfer_op  = 8'd4;
      forget_packet();
      reply_armed  = 1'b0;
      reply_opcode = '0;
      sampling     = 1'b0;
      expected_verdicts.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_START_SAMPLE:   start_op    = cfg_data;
          REG_STOP_SAMPLE:    stop_op     = cfg_data;
          REG_RESTART_SAMPLE: restart_op  = cfg_data;
          REG_START_TRANSFER: transfer_op = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        verdicts_checked++;
        if (expected_verdicts.size() == 0) begin
          report_mismatch($sformatf("verdict %0d arrived with none expected",
                                    verdicts_checked));
        end else begin
          want = expected_verdicts.pop_front();
          check_field("verdict", 8'(out_data.verdict), 8'(want.verdict));
          check_field("rx_opcode", out_data.rx_opcode, want.rx_opcode);
          check_field("ack_opcode", out_data.ack_opcode, want.ack_opcode);
          check_field("ack_needed", 8'(out_data.ack_needed), 8'(want.ack_needed));
          check_field("sampling_on", 8'(out_data.sampling_on), 8'(want.sampling_on));
        end
      end
      if (in_valid && !in_stall) take_beat(in_data);
    end
    verdicts_pending = expected_verdicts.size();
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// testbench: drives frames, local commands and opcode settings into
// command_frame_checker; cfc_checker predicts and compares, uses cfc_pkg
module testbench;
  import cfc_pkg::*;

  localparam logic [7:0] SYNC_0      = 8'h4A;
  localparam logic [7:0] SYNC_1      = 8'h48;
  localparam logic [7:0] REPLY_BIT   = 8'h80;
  localparam int         HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int         SETTLE      = 8;     // queue depth plus pipeline
  localparam int         LIMIT       = 3000;  // cycles with no beat moving

  typedef enum int {FLAW_NONE, FLAW_HEADER, FLAW_CHECKSUM, FLAW_LENGTH, FLAW_SHORT}
    frame_flaw_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_beat_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_beat_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  int unsigned fail_count;
  int unsigned verdicts_pending;
  int unsigned verdicts_checked;

  // stimulus-side bookkeeping
  logic [7:0]  pkt[$];          // bytes of the packet being built
  logic [7:0]  cur_ops[4];      // opcodes currently written, by register index
  logic [7:0]  last_cmd;        // opcode of the latest local command
  bit          hold_req;        // asks the receiver for one long hold-off
  bit          calm;            // no idling on either side
  int unsigned beats_sent;
  int          idle_run;

  command_frame_checker DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cfc_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .verdicts_pending (verdicts_pending),
    .verdicts_checked (verdicts_checked)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver side: random stall bursts, one long hold-off on request,
  // none once the run goes calm
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: ends the run when no beat moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_run <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_run <= 0;
    end else if (idle_run + 1 >= LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  // one input beat: optional idle burst first, then hold it until taken
  task automatic send_beat(input logic k, input logic [7:0] d, input logic eop);
    @(negedge clk);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{kind: k, data_byte: d, end_of_packet: eop};
    do @(posedge clk); while (in_stall);
    beats_sent++;
    if (k) last_cmd = d;
  endtask

  // send pkt, end mark on the last byte; local commands may slip in between
  task automatic send_packet(input bit mix_cmds);
    foreach (pkt[i]) begin
      if (mix_cmds && $urandom_range(0, 39) == 0)
        send_beat(1'b1, 8'($urandom), 1'($urandom));
      send_beat(1'b0, pkt[i], i == pkt.size() - 1);
    end
  endtask

  // header, version, opcode, length, payload, additive checksum, then a flaw
  task automatic build_frame(input logic [7:0] op, input int plen,
                             input frame_flaw_t flaw);
    logic [7:0] sum;
    int         pos;
    pkt.delete();
    pkt.push_back(SYNC_0);
    pkt.push_back(SYNC_1);
    pkt.push_back(8'($urandom));
    pkt.push_back(op);
    pkt.push_back(8'(plen));
    repeat (plen) pkt.push_back(8'($urandom));
    sum = '0;
    foreach (pkt[i]) sum = sum + pkt[i];
    pkt.push_back(sum);
    case (flaw)
      FLAW_HEADER: begin
        pos = $urandom_range(0, 1);
        pkt[pos] = pkt[pos] ^ 8'($urandom_range(1, 255));
      end
      FLAW_CHECKSUM: pkt[pkt.size() - 1] = sum ^ 8'($urandom_range(1, 255));
      FLAW_LENGTH: begin
        // either the length byte lies or an extra byte sneaks in
        if ($urandom_range(0, 1)) pkt[4] = pkt[4] + 8'($urandom_range(1, 255));
        else pkt.insert(5, 8'($urandom));
      end
      FLAW_SHORT: begin
        pos = $urandom_range(2, 5);
        while (pkt.size() > pos) void'(pkt.pop_back());
      end
      default: ;
    endcase
  endtask

  // mostly configured opcodes or the awaited reply, some arbitrary
  function automatic logic [7:0] pick_opcode();
    case ($urandom_range(0, 6))
      0, 1, 2, 3: return cur_ops[$urandom_range(0, 3)];
      4:          return last_cmd | REPLY_BIT;
      default:    return 8'($urandom);
    endcase
  endfunction

  // short payloads mostly, now and then a longer one that can run past the frame size limit
  function automatic int pick_length();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 20);
    return $urandom_range(0, 4);
  endfunction

  task automatic random_traffic(input int n);
    int unsigned target;
    int          r;
    target = beats_sent + n;
    while (beats_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        // local command, often answered by its reply
        send_beat(1'b1, 8'($urandom), 1'($urandom));
        if ($urandom_range(0, 1)) begin
          build_frame(last_cmd | REPLY_BIT, pick_length(), FLAW_NONE);
          send_packet(1'b1);
        end
      end else begin
        if (r < 56)      build_frame(pick_opcode(), pick_length(), FLAW_NONE);
        else if (r < 66) build_frame(pick_opcode(), pick_length(), FLAW_CHECKSUM);
        else if (r < 74) build_frame(pick_opcode(), pick_length(), FLAW_HEADER);
        else if (r < 82) build_frame(pick_opcode(), pick_length(), FLAW_LENGTH);
        else if (r < 90) build_frame(pick_opcode(), pick_length(), FLAW_SHORT);
        else begin
          // line noise
          pkt.delete();
          repeat ($urandom_range(1, 8)) pkt.push_back(8'($urandom));
        end
        send_packet(1'b1);
      end
    end
  endtask

  // drop valid, wait for every verdict, then let queued commands drain
  task automatic go_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (verdicts_pending == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_ops[idx] = val;
  endtask

  task automatic set_opcodes(input logic [7:0] a, input logic [7:0] b,
                             input logic [7:0] c, input logic [7:0] d);
    write_reg(REG_START_SAMPLE, a);
    write_reg(REG_STOP_SAMPLE, b);
    write_reg(REG_RESTART_SAMPLE, c);
    write_reg(REG_START_TRANSFER, d);
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_index  = REG_START_SAMPLE;
    cfg_data   = '0;
    hold_req   = 1'b0;
    calm       = 1'b0;
    last_cmd   = '0;
    beats_sent = 0;
    cur_ops    = '{8'd1, 8'd2, 8'd3, 8'd4};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: one-byte packet with a good first byte is still a bad header
    pkt = {SYNC_0};
    send_packet(1'b0);
    // good header, two bytes: bad length, opcode absent
    pkt = {SYNC_0, SYNC_1};
    send_packet(1'b0);
    // four bytes: bad length, opcode present
    pkt = {SYNC_0, SYNC_1, 8'h00, 8'hFF};
    send_packet(1'b0);
    // local command with the end mark set: the mark is ignored, it arms the wait for 0x85
    send_beat(1'b1, 8'h05, 1'b1);
    // the awaited reply, empty payload
    build_frame(8'h85, 0, FLAW_NONE);
    send_packet(1'b0);
    // start sampling at reset opcodes
    build_frame(8'h01, 0, FLAW_NONE);
    send_packet(1'b0);
    // single zero byte
    pkt = {8'h00};
    send_packet(1'b0);
    go_quiet();

    // reset opcodes
    random_traffic(320);
    go_quiet();

    // extreme opcodes; receiver holds off while the sender keeps offering
    set_opcodes(8'h00, 8'hFF, 8'h7F, 8'h80);
    hold_req = 1'b1;
    repeat (30) begin
      pkt = {8'($urandom)};
      send_packet(1'b0);
    end
    random_traffic(320);
    go_quiet();

    // overlapping opcodes; start wins over stop, restart over transfer
    set_opcodes(8'h55, 8'h55, 8'hAA, 8'hAA);
    // oversize packet that drives the byte count into saturation
    pkt = {SYNC_0, SYNC_1};
    repeat (298) pkt.push_back(8'($urandom));
    send_packet(1'b0);
    random_traffic(320);
    go_quiet();

    // random opcodes, no idling on either side
    set_opcodes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    calm = 1'b1;
    random_traffic(320);
    go_quiet();
    repeat (SETTLE) @(posedge clk);

    $display("run covered %0d input beats and %0d verdicts across four opcode settings",
             beats_sent, verdicts_checked);
    $display("incl. overlapping and extreme opcodes, a 300 byte packet, a %0d cycle hold",
             HOLD_CYCLES);
    if (fail_count == 0 && verdicts_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
